// ----- src/msbg_pkg.sv -----
// ----------------------------------------------------------------------------
// msbg_pkg: shared definitions for the modular squaring bit generator
// Widths, modulus constants and sequencer states.
// ----------------------------------------------------------------------------
package msbg_pkg;

    localparam int MAX_BITS_DEF = 32;
    localparam int OUT_W        = 32;
    localparam int REQ_W        = 6;
    localparam int ST_W         = 16;
    localparam int WORK_W       = 32;
    localparam int RED_W        = 17;

    localparam logic [RED_W-1:0] MODULUS = 17'd64829;
    localparam logic [9:0]       FOLD_K  = 10'd707;   // 2^16 mod 64829
    localparam logic [ST_W-1:0]  SEED    = 16'h667d;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_F1,
        ST_F2,
        ST_F3,
        ST_HOLD
    } seq_state_t;

endpackage

// ----- src/modular_squaring_bit_generator.sv -----
// ----------------------------------------------------------------------------
// modular_squaring_bit_generator: squaring-mod-64829 random bit source
// One shared multiply-add unit squares the state and makes two folds; a
// final fold and subtract bring it below 64829; one bit is drawn per squaring.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  req     | req_valid, req_ready, bit_count  | in
//  rsp     | rsp_valid, rsp_ready, random_bits| out
//
//  A request of n bits (n saturated to MAX_BITS) runs one round per bit:
//  each bit is square, two multiply folds by 707, final fold and subtract.
//  A zero request goes straight from idle to the output hold state.
//  req_ready is high only while the sequencer is idle; a finished beat waits
//  in the output register while the next request is taken.
//  Reset loads the state with 0x667d.
module modular_squaring_bit_generator #(
    parameter int MAX_BITS = msbg_pkg::MAX_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [msbg_pkg::REQ_W-1:0]  bit_count,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [msbg_pkg::OUT_W-1:0]  random_bits
);
    import msbg_pkg::*;

    localparam int CNT_W = $clog2(MAX_BITS + 1);

    seq_state_t            st_reg, st_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [ST_W-1:0]       gen_state_reg, gen_state_next;
    logic [WORK_W-1:0]     work_reg, work_next;
    logic [MAX_BITS-1:0]   bits_reg, bits_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [OUT_W-1:0]      random_bits_reg, random_bits_next;

    logic [ST_W-1:0]       mul_a, mul_b, mul_add;
    logic [WORK_W-1:0]     mac;
    logic [3:0]            hi_small;
    logic [RED_W-1:0]      fold_sum, red;
    logic                  load_out;

    assign mac = (WORK_W'(mul_a) * WORK_W'(mul_b)) + WORK_W'(mul_add);

    assign hi_small = work_reg[19:16];
    assign fold_sum = {1'b0, work_reg[ST_W-1:0]} + (RED_W'(hi_small) * RED_W'(FOLD_K));
    assign red      = (fold_sum >= MODULUS) ? (fold_sum - MODULUS) : fold_sum;

    assign load_out = (st_reg == ST_HOLD) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        st_next          = st_reg;
        cnt_next         = cnt_reg;
        gen_state_next   = gen_state_reg;
        work_next        = work_reg;
        bits_next        = bits_reg;
        rsp_valid_next   = rsp_valid_reg;
        random_bits_next = random_bits_reg;
        mul_a            = gen_state_reg;
        mul_b            = gen_state_reg;
        mul_add          = '0;
        req_ready        = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (st_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    bits_next = '0;
                    if (bit_count > REQ_W'(MAX_BITS))
                    begin
                        cnt_next = CNT_W'(MAX_BITS);
                    end
                    else
                    begin
                        cnt_next = bit_count[CNT_W-1:0];
                    end
                    st_next = (bit_count == '0) ? ST_HOLD : ST_SQ;
                end
            end
            ST_SQ:
            begin
                work_next = mac;
                st_next   = ST_F1;
            end
            ST_F1, ST_F2:
            begin
                mul_a     = work_reg[WORK_W-1:ST_W];
                mul_b     = ST_W'(FOLD_K);
                mul_add   = work_reg[ST_W-1:0];
                work_next = mac;
                st_next   = (st_reg == ST_F1) ? ST_F2 : ST_F3;
            end
            ST_F3:
            begin
                gen_state_next = red[ST_W-1:0];
                bits_next      = MAX_BITS'({bits_reg, red[0]});
                cnt_next       = cnt_reg - CNT_W'(1);
                st_next        = (cnt_reg == CNT_W'(1)) ? ST_HOLD : ST_SQ;
            end
            ST_HOLD:
            begin
                if (load_out)
                begin
                    rsp_valid_next   = 1'b1;
                    random_bits_next = OUT_W'(bits_reg);
                    st_next          = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            cnt_reg       <= '0;
            gen_state_reg <= SEED;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            cnt_reg       <= cnt_next;
            gen_state_reg <= gen_state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg        <= work_next;
        bits_reg        <= bits_next;
        random_bits_reg <= random_bits_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign random_bits = random_bits_reg;

`ifndef NO_ASSERTIONS
    a_f3_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_F3) |-> (work_reg[WORK_W-1:20] == '0))
        else $error("fold residue too wide before final step");

    a_state_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_F3) |=> (RED_W'(gen_state_reg) < MODULUS))
        else $error("state not reduced below modulus");

    a_sq_count: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_SQ) |-> (cnt_reg != '0))
        else $error("squaring with no bits left");

    a_zero_req: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (bit_count == '0)) |=> (st_reg == ST_HOLD))
        else $error("zero request did not go straight to output");

    a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (rsp_valid && (st_reg == ST_IDLE)))
        else $error("output beat not presented after load");
`endif

endmodule

// ----- tb/modular_squaring_bit_generator_tb.sv -----
// ----------------------------------------------------------------------------
// modular_squaring_bit_generator_tb: self-checking bench for the bit generator
// A short table of directed requests, then bursts of random requests, with
// the response side stalling on its own pattern. Every response beat is
// checked against the table's known value or a local squaring-mod-64829 predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modular_squaring_bit_generator_tb;

    localparam int RANDOM_REQS = 850;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_TAIL  = 150;

    typedef logic [msbg_pkg::REQ_W-1:0] count_t;

    typedef struct {
        logic [msbg_pkg::REQ_W-1:0] count;
        bit                         known;
        logic [msbg_pkg::OUT_W-1:0] bits;
    } req_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        req_valid;
    logic                        req_ready;
    logic [msbg_pkg::REQ_W-1:0]  bit_count;
    logic                        rsp_valid;
    logic                        rsp_ready;
    logic [msbg_pkg::OUT_W-1:0]  random_bits;

    logic [msbg_pkg::ST_W-1:0]   squaring_state;
    logic [msbg_pkg::OUT_W-1:0]  expected_bits [$];
    req_row_t                    directed_rows [0:13];
    int                          errors;
    int                          accepted_reqs;
    bit                          hold_done;

    modular_squaring_bit_generator uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .bit_count   (bit_count),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .random_bits (random_bits)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [msbg_pkg::OUT_W-1:0] predict_bits(
        input logic [msbg_pkg::REQ_W-1:0] count);
        int unsigned                 n;
        logic [31:0]                 sq;
        logic [msbg_pkg::OUT_W-1:0]  acc;
        n   = (count > msbg_pkg::MAX_BITS_DEF) ? msbg_pkg::MAX_BITS_DEF : count;
        acc = '0;
        for (int i = 0; i < n; i++)
        begin
            sq = ({16'd0, squaring_state} * {16'd0, squaring_state})
                 % {15'd0, msbg_pkg::MODULUS};
            squaring_state = sq[msbg_pkg::ST_W-1:0];
            acc = {acc[msbg_pkg::OUT_W-2:0], sq[0]};
        end
        return acc;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [msbg_pkg::OUT_W-1:0] got,
                                   input logic [msbg_pkg::OUT_W-1:0] want);
        $display("ERROR @%0t: %s: got %08h, want %08h", $realtime, what, got, want);
        errors++;
    endtask

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_request(input logic [msbg_pkg::REQ_W-1:0] count,
                                input bit known,
                                input logic [msbg_pkg::OUT_W-1:0] bits);
        logic [msbg_pkg::OUT_W-1:0] predicted;
        req_valid <= 1'b1;
        bit_count <= count;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = predict_bits(count);
        expected_bits.push_back(known ? bits : predicted);
        accepted_reqs++;
        @(negedge clk);
    endtask

    task automatic pause_until_drained();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_bits.size() != 0);
    endtask

    task automatic idle_gap(input int unsigned cycles);
        if (cycles != 0)
        begin
            req_valid <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    function automatic logic [msbg_pkg::REQ_W-1:0] random_count();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return count_t'(msbg_pkg::MAX_BITS_DEF);
            2: return '1;
            3: return count_t'($urandom_range(msbg_pkg::MAX_BITS_DEF + 1, 63));
            default: return count_t'($urandom_range(0, 63));
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_bits.size() == 0)
                report_mismatch("beat with nothing pending", random_bits, '0);
            else
            begin
                if (random_bits !== expected_bits[0])
                    report_mismatch("random_bits", random_bits, expected_bits[0]);
                void'(expected_bits.pop_front());
            end
        end
    end

    // response side: segments of differing stall patterns, one long hold-off
    initial
    begin
        int unsigned mode;
        int unsigned seg;
        rsp_ready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(10, 150);
            if (!hold_done && accepted_reqs >= 300)
            begin
                hold_done = 1'b1;
                @(negedge clk);
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                for (int i = 0; i < seg; i++)
                begin
                    @(negedge clk);
                    case (mode)
                        0: rsp_ready <= 1'b1;
                        1: rsp_ready <= 1'($urandom_range(0, 1));
                        2: rsp_ready <= (i % 4 == 0);
                        default: rsp_ready <= (i % 8 < 5);
                    endcase
                end
            end
        end
    end

    initial
    begin
        #12_000_000;
        $display("modular_squaring_bit_generator_tb: FAIL");
        $finish;
    end

    initial
    begin
        int unsigned burst;
        int unsigned sent;

        rst_n          = 1'b0;
        req_valid      = 1'b0;
        bit_count      = '0;
        errors         = 0;
        accepted_reqs  = 0;
        hold_done      = 1'b0;
        squaring_state = msbg_pkg::SEED;

        // first bit after reset is 1; zero requests return 0
        directed_rows = '{
            '{6'd1,  1'b1, 32'd1},
            '{6'd0,  1'b1, 32'd0},
            '{6'd32, 1'b0, 32'd0},
            '{6'd63, 1'b0, 32'd0},
            '{6'd0,  1'b1, 32'd0},
            '{6'd33, 1'b0, 32'd0},
            '{6'd31, 1'b0, 32'd0},
            '{6'd2,  1'b0, 32'd0},
            '{6'd1,  1'b0, 32'd0},
            '{6'd16, 1'b0, 32'd0},
            '{6'd48, 1'b0, 32'd0},
            '{6'd3,  1'b0, 32'd0},
            '{6'd0,  1'b1, 32'd0},
            '{6'd62, 1'b0, 32'd0}
        };

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].count, directed_rows[i].known,
                         directed_rows[i].bits);
            idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 40));
        end

        pause_until_drained();

        sent = 0;
        while (sent < RANDOM_REQS)
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < RANDOM_REQS; b++)
            begin
                send_request(random_count(), 1'b0, '0);
                sent++;
                if (sent == RANDOM_REQS / 2)
                    pause_until_drained();
            end
            idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30));
        end

        req_valid <= 1'b0;
        while (expected_bits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        if (errors == 0 && expected_bits.size() == 0)
            $display("modular_squaring_bit_generator_tb: PASS");
        else
            $display("modular_squaring_bit_generator_tb: FAIL");
        $finish;
    end

endmodule
